@@ src/sine_waveshaper_stereo_assert.svh @@
// assertion macros for the sine waveshaper
`ifndef SINE_WAVESHAPER_STEREO_ASSERT_SVH
`define SINE_WAVESHAPER_STEREO_ASSERT_SVH
// implication checked every clock edge outside reset
`define SWS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SWS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/sws_pkg.sv @@
// package with constants, types and the arctangent table of the waveshaper
package sws_pkg;
  localparam int SampleBits = 24;
  localparam int FracBits   = SampleBits - 2;
  localparam int SineBits   = 20;
  localparam int Depth      = SineBits + 5;
  localparam int AngW       = 36;
  localparam int CordW      = 34;
  localparam logic signed [AngW-1:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [AngW-1:0] Q30TwoPi  = 36'sd6746518852;
  localparam logic signed [AngW-1:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [CordW-1:0] CordInit = 34'sd652032874;
  localparam logic [3:0] AddrOverdrive = 4'h0;
  localparam logic [3:0] AddrPhase     = 4'h4;
  localparam logic [3:0] AddrShape     = 4'h8;
  localparam logic [3:0] AddrClip      = 4'hC;

  typedef logic signed [SampleBits-1:0] sample_t;

  // per-channel data moving along the row
  typedef struct packed {
    logic                    clip;
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0]  z;
  } cord_t;

  function automatic logic signed [AngW-1:0] atan_q30(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
      24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
      27: t = 32'h00000008; 28: t = 32'h00000004; 29: t = 32'h00000002;
      default: t = 32'h00000000;
    endcase
    return $signed({4'b0, t});
  endfunction
endpackage

@@ src/sws_cell.sv @@
// one cordic rotation cell for both channels, registered
module sws_cell import sws_pkg::*; (
  input  logic             clk,
  input  logic [4:0]       idx,
  input  logic             en,
  input  cord_t            l_in,
  input  cord_t            r_in,
  output cord_t            l_out,
  output cord_t            r_out
);
  function automatic cord_t rot(input cord_t c, input logic [4:0] s);
    cord_t o;
    o = c;
    if (c.z >= 0) begin
      o.x = c.x - (c.y >>> s);
      o.y = c.y + (c.x >>> s);
      o.z = c.z - atan_q30(int'(s));
    end else begin
      o.x = c.x + (c.y >>> s);
      o.y = c.y - (c.x >>> s);
      o.z = c.z + atan_q30(int'(s));
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      l_out <= rot(l_in, idx);
      r_out <= rot(r_in, idx);
    end
  end
endmodule

@@ src/sine_waveshaper_stereo.sv @@
// top level of the stereo sine waveshaper
// usage:
// - in_ channel takes one stereo word per cycle while in_stall is low (in_valid, in_stall)
// - out_ channel returns one shaped stereo word per input word
// - cfg_ port is apb-style; registers at 0x0 overdrive, 0x4 phase_gain,
//   0x8 shape_gain, 0xC clip_level; write only while idle
// - overdrive zero bypasses shaping, samples pass unchanged
// - pipeline: phase multiply, floor shift, modulo reduce, fold,
//   20 cordic cells, gain multiply, round and saturate
// - throughput one word per cycle when nothing stalls
// - the pipeline moves as one; an out_stall freezes every stage and
//   raises in_stall only when the output stage holds a word
// - synchronous reset clears valid bits and the config registers (bypass)
module sine_waveshaper_stereo import sws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  sample_t     in_left_sample,
  input  sample_t     in_right_sample,
  output logic        out_valid,
  input  logic        out_stall,
  output sample_t     out_left_shaped,
  output sample_t     out_right_shaped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  `include "sine_waveshaper_stereo_assert.svh"

  // configuration registers
  logic [13:0]        od_r;
  logic [22:0]        pg_r;
  logic signed [31:0] sg_r;
  logic [22:0]        cl_r;
  logic               wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      od_r <= '0; pg_r <= '0; sg_r <= '0; cl_r <= '0;
    end else if (wr) begin
      unique case (paddr)
        AddrOverdrive: od_r <= pwdata[13:0];
        AddrPhase:     pg_r <= pwdata[22:0];
        AddrShape:     sg_r <= pwdata;
        AddrClip:      cl_r <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrOverdrive: prdata = {18'b0, od_r};
      AddrPhase:     prdata = {9'b0, pg_r};
      AddrShape:     prdata = sg_r;
      AddrClip:      prdata = {9'b0, cl_r};
      default:       prdata = '0;
    endcase
  end

  // global pipeline enable: advance unless a held output is stalled
  logic [Depth-1:0] v_r;
  logic             adv;
  assign adv = !(v_r[Depth-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = v_r[Depth-1];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[Depth-2:0], in_valid};
  end

  // bypass bit and raw samples follow the pipeline up to the final stage
  logic    byp_r  [Depth-1];
  sample_t rawl_r [Depth-1];
  sample_t rawr_r [Depth-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      byp_r[0] <= (od_r == '0);
      rawl_r[0] <= in_left_sample;
      rawr_r[0] <= in_right_sample;
      for (int i = 1; i < Depth - 1; i++) begin
        byp_r[i] <= byp_r[i-1];
        rawl_r[i] <= rawl_r[i-1];
        rawr_r[i] <= rawr_r[i-1];
      end
    end
  end

  // stage 0: phase multiply and clip compare
  logic signed [47:0] pl_r, pr_r;
  logic               cl0l_r, cl0r_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r <= $signed({1'b0, pg_r}) * in_left_sample;
      pr_r <= $signed({1'b0, pg_r}) * in_right_sample;
      cl0l_r <= in_left_sample > $signed({1'b0, cl_r});
      cl0r_r <= in_right_sample > $signed({1'b0, cl_r});
    end
  end

  // stage 1: floor shift and modulo by 2 pi (magnitude at most 2^36,
  // parallel compares pick the multiple of 2 pi to remove)
  function automatic logic signed [AngW-1:0] reduce(input logic signed [47:0] p);
    logic signed [39:0] r;
    logic signed [39:0] tp;
    logic signed [39:0] step;
    logic signed [39:0] off;
    r = 40'(p >>> (SampleBits - 14));
    tp = 40'(Q30TwoPi);
    off = '0;
    for (int k = 1; k <= 10; k++) begin
      step = 40'(k) * tp;
      if (r >= step) off = step;
      else if (r < -step) off = -step;
    end
    r = r - off;
    if (r > 40'(Q30Pi)) r = r - tp;
    else if (r <= -40'(Q30Pi)) r = r + tp;
    return AngW'(r);
  endfunction

  logic signed [AngW-1:0] rl_r, rr_r;
  logic                   cl1l_r, cl1r_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      rl_r <= reduce(pl_r); rr_r <= reduce(pr_r);
      cl1l_r <= cl0l_r; cl1r_r <= cl0r_r;
    end
  end

  // stage 2: fold into half circle, load cordic
  function automatic cord_t fold(input logic signed [AngW-1:0] r, input logic c);
    cord_t o;
    o.clip = c;
    o.x = CordInit;
    o.y = '0;
    if (r > Q30HalfPi) o.z = Q30Pi - r;
    else if (r < -Q30HalfPi) o.z = -Q30Pi - r;
    else o.z = r;
    return o;
  endfunction

  cord_t cl_c [SineBits+1];
  cord_t cr_c [SineBits+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      cl_c[0] <= fold(rl_r, cl1l_r);
      cr_c[0] <= fold(rr_r, cl1r_r);
    end
  end

  // row of cordic cells
  for (genvar g = 0; g < SineBits; g++) begin : g_cell
    sws_cell u_cell (
      .clk(clk), .idx(5'(g)), .en(adv),
      .l_in(cl_c[g]), .r_in(cr_c[g]),
      .l_out(cl_c[g+1]), .r_out(cr_c[g+1])
    );
  end

  // gain multiply
  logic signed [65:0] ml_r, mr_r;
  logic               ckl_r, ckr_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ml_r <= cl_c[SineBits].y * sg_r;
      mr_r <= cr_c[SineBits].y * sg_r;
      ckl_r <= cl_c[SineBits].clip;
      ckr_r <= cr_c[SineBits].clip;
    end
  end

  // round, saturate and select
  function automatic sample_t finish(input logic signed [65:0] m, input logic c,
                                     input logic b, input sample_t raw);
    logic signed [65:0] o;
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    o = (m + (66'sd1 <<< (51 - FracBits - 1))) >>> (51 - FracBits);
    hi = (66'sd1 <<< (SampleBits - 1)) - 66'sd1;
    lo = -(66'sd1 <<< (SampleBits - 1));
    if (b) return raw;
    if (c) return sample_t'(1 <<< FracBits);
    if (o > hi) return {1'b0, {(SampleBits-1){1'b1}}};
    if (o < lo) return {1'b1, {(SampleBits-1){1'b0}}};
    return o[SampleBits-1:0];
  endfunction

  sample_t ol_r, or_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ol_r <= finish(ml_r, ckl_r, byp_r[Depth-2], rawl_r[Depth-2]);
      or_r <= finish(mr_r, ckr_r, byp_r[Depth-2], rawr_r[Depth-2]);
    end
  end
  assign out_left_shaped = ol_r;
  assign out_right_shaped = or_r;

  `SWS_ASSERT_IMPL(a_stall_only_full, in_stall, out_valid && out_stall)
  `SWS_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
  `SWS_ASSERT_NEXT(a_hold_left, out_valid && out_stall, $stable(out_left_shaped))
endmodule

@@ test/sws_checker.sv @@
// checker for the stereo waveshaper: tracks the config port, predicts each word, compares results
module sws_checker import sws_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  sample_t     in_left_sample,
  input  sample_t     in_right_sample,
  input  logic        out_valid,
  input  logic        out_stall,
  input  sample_t     out_left_shaped,
  input  sample_t     out_right_shaped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          shaped_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PiQ30     = 64'sd3373259426;
  localparam longint TwoPiQ30  = 64'sd6746518852;
  localparam longint HalfPiQ30 = 64'sd1686629713;
  localparam longint GainStart = 64'sd652032874;
  localparam int     Rotations = 20;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } pair_t;

  // arctangent of 2^-i in q30
  localparam longint ArcTan [Rotations] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF};

  logic [13:0]        overdrive;
  logic [22:0]        phase_gain;
  logic signed [31:0] shape_gain;
  logic [22:0]        clip_level;
  pair_t              shaped_q[$];

  function automatic longint cordic_sine(longint angle);
    longint r, cx, cy, cz, nx;
    r = angle % TwoPiQ30;
    if (r < 0) r += TwoPiQ30;
    if (r > PiQ30) r -= TwoPiQ30;
    if (r > HalfPiQ30) r = PiQ30 - r;
    else if (r < -HalfPiQ30) r = -PiQ30 - r;
    cx = GainStart;
    cy = 0;
    cz = r;
    for (int i = 0; i < Rotations; i++) begin
      if (cz >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        cz -= ArcTan[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        cz += ArcTan[i];
      end
      cx = nx;
    end
    return cy;
  endfunction

  function automatic sample_t shape_sample(sample_t s);
    longint xv, angle, prod, o;
    xv = s;
    if (xv > longint'(clip_level)) return sample_t'(1 << FracBits);
    angle = (longint'(phase_gain) * xv) >>> 10;
    prod = cordic_sine(angle) * longint'(shape_gain);
    o = (prod + (64'sd1 <<< 28)) >>> 29;
    if (o > 64'sd8388607) o = 64'sd8388607;
    if (o < -64'sd8388608) o = -64'sd8388608;
    return sample_t'(o);
  endfunction

  assign pending = shaped_q.size();

  always @(posedge clk) begin
    pair_t want;
    int    bad;
    bad = 0;
    if (!rst_n) begin
      overdrive  <= '0;
      phase_gain <= '0;
      shape_gain <= '0;
      clip_level <= '0;
      errors     <= 0;
      shaped_count <= 0;
      shaped_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          AddrOverdrive: overdrive  <= pwdata[13:0];
          AddrPhase:     phase_gain <= pwdata[22:0];
          AddrShape:     shape_gain <= pwdata;
          AddrClip:      clip_level <= pwdata[22:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (overdrive == 0) begin
          want.left  = in_left_sample;
          want.right = in_right_sample;
        end else begin
          want.left  = shape_sample(in_left_sample);
          want.right = shape_sample(in_right_sample);
        end
        shaped_q = {shaped_q, want};
      end
      if (out_valid && !out_stall) begin
        if (shaped_q.size() == 0) begin
          $error("result word with nothing expected: %0d %0d", out_left_shaped,
                 out_right_shaped);
          bad++;
        end else begin
          want = shaped_q.pop_front();
          shaped_count <= shaped_count + 1;
          if (out_left_shaped !== want.left) begin
            $error("left_shaped: expected %0d, got %0d", want.left, out_left_shaped);
            bad++;
          end
          if (out_right_shaped !== want.right) begin
            $error("right_shaped: expected %0d, got %0d", want.right, out_right_shaped);
            bad++;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
  end
endmodule

@@ test/testbench.sv @@
// top of the waveshaper testbench: clock, reset, stimulus, config writes and verdict
module testbench import sws_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  sample_t     in_left_sample = '0;
  sample_t     in_right_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  sample_t     out_left_shaped;
  sample_t     out_right_shaped;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending, shaped_count;
  int words_sent = 0;
  int sender_idle_pct = 27;   // percent of cycles the sender holds back
  int receiver_idle_pct = 77; // percent of cycles the receiver stalls
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic [22:0] cur_clip = '0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sine_waveshaper_stereo i_dut (.*);

  sws_checker i_checker (.*);

  // receiver: random stall, plus one long hold-off mid run so the pipe fills
  always @(negedge clk) begin
    if (!hold_done && words_sent >= 1100) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // offer one stereo word, with random gaps first; returns at the falling edge after acceptance
  task automatic send_word(input sample_t l, input sample_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      in_left_sample  <= sample_t'($urandom);
      in_right_sample <= sample_t'($urandom);
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_left_sample  <= l;
    in_right_sample <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    words_sent++;
    // idling schedule: sender light, then receiver light, then none
    if (words_sent == 480) begin
      sender_idle_pct   = 77;
      receiver_idle_pct = 27;
    end else if (words_sent == 960) begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
  endtask

  // apb write: setup cycle then access cycle, then back to idle
  task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // drain the pipe, then load a full register set
  task automatic load_setting(input logic [13:0] od, input logic [22:0] pg,
                              input logic [31:0] sg, input logic [22:0] cl);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    reg_write(AddrOverdrive, {18'b0, od});
    reg_write(AddrPhase, {9'b0, pg});
    reg_write(AddrShape, sg);
    reg_write(AddrClip, {9'b0, cl});
    cur_clip = cl;
  endtask

  // software-style gains for an overdrive in thousandths
  task automatic load_overdrive(input int od);
    real a, pg, sg, cl;
    a = od / 1000.0;
    if (a == $floor(a)) a = a - 0.1;
    pg = 3.14159265358979 * a * 262144.0;
    sg = 2097152.0 / $sin(3.14159265358979 * a);
    cl = 4194304.0 / a;
    if (pg > 8388607.0) pg = 8388607.0;
    if (cl > 8388607.0) cl = 8388607.0;
    if (sg > 2147483647.0) sg = 2147483647.0;
    if (sg < -2147483648.0) sg = -2147483648.0;
    load_setting(od[13:0], 23'($rtoi(pg)), 32'($rtoi(sg)), 23'($rtoi(cl)));
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(4))
      0: return sample_t'($urandom);
      1: return sample_t'($signed($urandom_range(8388608)) - 4194304);
      2: return sample_t'({1'b0, cur_clip} + $urandom_range(8) - 4);
      3: return sample_t'($signed($urandom_range(2048)) - 1024);
      default: return $urandom_range(1) ? sample_t'(24'h7FFFFF) : sample_t'(24'h800000);
    endcase
  endfunction

  task automatic random_words(input int n);
    repeat (n) send_word(pick_sample(), pick_sample());
  endtask

  // edge values: zero, extremes, +-1.0, clip level and one above, +-1 lsb, alternating bits
  task automatic directed_words();
    send_word('0, '0);
    send_word(sample_t'(24'h7FFFFF), sample_t'(24'h800000));
    send_word(sample_t'(24'h400000), sample_t'(-24'sd4194304));
    send_word(sample_t'({1'b0, cur_clip}), sample_t'({1'b0, cur_clip} + 1));
    send_word(sample_t'(24'h000001), sample_t'(24'hFFFFFF));
    send_word(sample_t'(24'h555555), sample_t'(24'hAAAAAA));
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // bypass straight out of reset
    directed_words();
    random_words(150);

    load_overdrive(100);
    directed_words();
    random_words(250);

    load_overdrive(2550);
    directed_words();
    random_words(250);

    // whole overdrive value, the software backs it off by 0.1
    load_overdrive(10000);
    directed_words();
    random_words(250);

    // register extremes, used as given
    load_setting(14'h3FFF, 23'h7FFFFF, 32'h8000_0000, 23'h000000);
    directed_words();
    random_words(200);

    load_setting(14'h0001, 23'h000000, 32'h7FFF_FFFF, 23'h7FFFFF);
    directed_words();
    random_words(100);

    load_setting(14'h0001, 23'h7FFFFF, 32'h0000_0000, 23'h200000);
    random_words(100);

    // back to bypass with stale gains left in place
    load_setting(14'h0000, 23'h123456, 32'h0040_0000, 23'h100000);
    directed_words();
    random_words(100);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("covered %0d stereo words over bypass, software gains and register extremes,",
             words_sent);
    $display("with idle and stall mixes and one long output hold-off; %0d results checked",
             shaped_count);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end
endmodule
